// ===== hw/rtl/mild_pkg.sv =====
// Shared types and constants for the sync/ID/length deframer.
// Used by magic_id_length_deframer_unit and mild_checker; no dependencies.
package mild_pkg;

    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned LEN_W   = 7;
    localparam int unsigned INDEX_W = 6;
    localparam int unsigned OUT_W   = 24;

    localparam logic [7:0] SYNC_RESET = 8'h7F;
    localparam logic [LEN_W-1:0] LEN_RESET = 7'd1;

    // Known frame IDs
    localparam logic [7:0] ID_HEARTBEAT     = 8'd4;
    localparam logic [7:0] ID_MOTION_RATE   = 8'd6;
    localparam logic [7:0] ID_GIMBAL        = 8'd12;
    localparam logic [7:0] ID_FIRING        = 8'd13;
    localparam logic [7:0] ID_SURVEIL       = 8'd15;
    localparam logic [7:0] ID_AIM           = 8'd16;
    localparam logic [7:0] ID_NAVIGATING    = 8'd17;

    // Register index (byte address / 4)
    typedef enum logic [2:0] {
        REG_SYNC_BYTE         = 3'd0,
        REG_LEN_HEARTBEAT     = 3'd1,
        REG_LEN_CHASSIS_SPEED = 3'd2,
        REG_LEN_GIMBAL        = 3'd3,
        REG_LEN_FIRING        = 3'd4,
        REG_LEN_SURVEIL       = 3'd5,
        REG_LEN_AIM           = 3'd6,
        REG_LEN_NAVIGATING    = 3'd7
    } cfg_reg_t;

endpackage

// ===== hw/rtl/magic_id_length_deframer_unit.sv =====
// An accepted payload byte passes the input register and then the result register before it is
// shown on m_tvalid/m_tdata. Throughput: one item per cycle, set by the compare/counter
// step between the two registers; stalls only on m_tready.
// Reset (rst_n low, asynchronous): parser hunts for sync, pipeline empty,
// sync_byte = 0x7F, all length registers = 1.
// Depends on mild_pkg.
module magic_id_length_deframer_unit #(
    parameter int unsigned MAX_PAYLOAD = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [mild_pkg::OUT_W-1:0]  m_tdata,   // [7:0] frame_id, [15:8] payload_byte,
                                                   // [21:16] byte_index, [23:22] zero
    output logic                        m_tlast,   // last_byte
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mild_pkg::ADDR_W-1:0] paddr,
    input  logic [mild_pkg::DATA_W-1:0] pwdata,
    output logic [mild_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import mild_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_ID   = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

    // configuration registers
    logic [7:0]       sync_byte_reg;
    logic [LEN_W-1:0] len_heartbeat_reg;
    logic [LEN_W-1:0] len_chassis_speed_reg;
    logic [LEN_W-1:0] len_gimbal_reg;
    logic [LEN_W-1:0] len_firing_reg;
    logic [LEN_W-1:0] len_surveil_reg;
    logic [LEN_W-1:0] len_aim_reg;
    logic [LEN_W-1:0] len_navigating_reg;

    logic     cfg_write;
    cfg_reg_t cfg_sel;

    // input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // parser state and result register
    phase_t           phase_reg, phase_next;
    logic [7:0]       held_id_reg, held_id_next;
    logic [LEN_W-1:0] frame_len_reg, frame_len_next;
    logic [LEN_W-1:0] byte_pos_reg, byte_pos_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_id_reg, out_id_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic [INDEX_W-1:0] out_index_reg, out_index_next;
    logic             out_last_reg, out_last_next;

    logic             out_free;
    logic             step;
    logic             id_known;
    logic [LEN_W-1:0] id_len;
    logic [LEN_W-1:0] id_len_sat;
    logic [LEN_W:0]   pos_inc;
    logic             is_last;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel   = cfg_reg_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_byte_reg         <= SYNC_RESET;
            len_heartbeat_reg     <= LEN_RESET;
            len_chassis_speed_reg <= LEN_RESET;
            len_gimbal_reg        <= LEN_RESET;
            len_firing_reg        <= LEN_RESET;
            len_surveil_reg       <= LEN_RESET;
            len_aim_reg           <= LEN_RESET;
            len_navigating_reg    <= LEN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                REG_SYNC_BYTE:         sync_byte_reg         <= pwdata[7:0];
                REG_LEN_HEARTBEAT:     len_heartbeat_reg     <= pwdata[LEN_W-1:0];
                REG_LEN_CHASSIS_SPEED: len_chassis_speed_reg <= pwdata[LEN_W-1:0];
                REG_LEN_GIMBAL:        len_gimbal_reg        <= pwdata[LEN_W-1:0];
                REG_LEN_FIRING:        len_firing_reg        <= pwdata[LEN_W-1:0];
                REG_LEN_SURVEIL:       len_surveil_reg       <= pwdata[LEN_W-1:0];
                REG_LEN_AIM:           len_aim_reg           <= pwdata[LEN_W-1:0];
                REG_LEN_NAVIGATING:    len_navigating_reg    <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_SYNC_BYTE:         prdata = DATA_W'(sync_byte_reg);
            REG_LEN_HEARTBEAT:     prdata = DATA_W'(len_heartbeat_reg);
            REG_LEN_CHASSIS_SPEED: prdata = DATA_W'(len_chassis_speed_reg);
            REG_LEN_GIMBAL:        prdata = DATA_W'(len_gimbal_reg);
            REG_LEN_FIRING:        prdata = DATA_W'(len_firing_reg);
            REG_LEN_SURVEIL:       prdata = DATA_W'(len_surveil_reg);
            REG_LEN_AIM:           prdata = DATA_W'(len_aim_reg);
            REG_LEN_NAVIGATING:    prdata = DATA_W'(len_navigating_reg);
            default:               prdata = '0;
        endcase
    end

    // ID lookup
    always_comb
    begin
        id_known = 1'b1;
        case (in_byte_reg)
            ID_HEARTBEAT:     id_len = len_heartbeat_reg;
            ID_MOTION_RATE:   id_len = len_chassis_speed_reg;
            ID_GIMBAL:        id_len = len_gimbal_reg;
            ID_FIRING:        id_len = len_firing_reg;
            ID_SURVEIL:       id_len = len_surveil_reg;
            ID_AIM:           id_len = len_aim_reg;
            ID_NAVIGATING:    id_len = len_navigating_reg;
            default:
            begin
                id_known = 1'b0;
                id_len   = '0;
            end
        endcase
        // clamp to MAX_PAYLOAD; MaxLen is below id_len here, so it fits
        if ({1'b0, id_len} > MaxLen)
            id_len_sat = MaxLen[LEN_W-1:0];
        else
            id_len_sat = id_len;
    end

    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign pos_inc  = {1'b0, byte_pos_reg} + 1'b1;
    assign is_last  = pos_inc >= {1'b0, frame_len_reg};

    always_comb
    begin
        phase_next     = phase_reg;
        held_id_next   = held_id_reg;
        frame_len_next = frame_len_reg;
        byte_pos_next  = byte_pos_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_id_next    = out_id_reg;
        out_byte_next  = out_byte_reg;
        out_index_next = out_index_reg;
        out_last_next  = out_last_reg;

        if (step)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (in_byte_reg == sync_byte_reg)
                        phase_next = PH_ID;
                end
                PH_ID:
                begin
                    held_id_next = in_byte_reg;
                    // unknown ID or zero length: back to hunting, byte not rechecked
                    if (!id_known || id_len_sat == '0)
                        phase_next = PH_HUNT;
                    else
                    begin
                        frame_len_next = id_len_sat;
                        byte_pos_next  = '0;
                        phase_next     = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    out_valid_next = 1'b1;
                    out_id_next    = held_id_reg;
                    out_byte_next  = in_byte_reg;
                    out_index_next = byte_pos_reg[INDEX_W-1:0];
                    out_last_next  = is_last;
                    byte_pos_next  = pos_inc[LEN_W-1:0];
                    if (is_last)
                        phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_byte_reg   <= '0;
            phase_reg     <= PH_HUNT;
            held_id_reg   <= '0;
            frame_len_reg <= '0;
            byte_pos_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_id_reg    <= '0;
            out_byte_reg  <= '0;
            out_index_reg <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
                in_byte_reg  <= s_tdata;
            end
            phase_reg     <= phase_next;
            held_id_reg   <= held_id_next;
            frame_len_reg <= frame_len_next;
            byte_pos_reg  <= byte_pos_next;
            out_valid_reg <= out_valid_next;
            out_id_reg    <= out_id_next;
            out_byte_reg  <= out_byte_next;
            out_index_reg <= out_index_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_index_reg, out_byte_reg, out_id_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== hw/rtl/mild_checker.sv =====
// Port-level checks for magic_id_length_deframer_unit, attached by bind below.
// Depends on mild_pkg.
module mild_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [mild_pkg::OUT_W-1:0]  m_tdata,
    input logic                        m_tlast,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [mild_pkg::ADDR_W-1:0] paddr,
    input logic [mild_pkg::DATA_W-1:0] pwdata,
    input logic [mild_pkg::DATA_W-1:0] prdata,
    input logic                        pready
);
    import mild_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // an empty result register never blocks input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // results only come from known IDs
    a_known_id: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:0] == ID_HEARTBEAT || m_tdata[7:0] == ID_MOTION_RATE ||
                      m_tdata[7:0] == ID_GIMBAL || m_tdata[7:0] == ID_FIRING ||
                      m_tdata[7:0] == ID_SURVEIL || m_tdata[7:0] == ID_AIM ||
                      m_tdata[7:0] == ID_NAVIGATING))
        else $error("result with unknown frame id");

    // sync byte readback after a write
    a_sync_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_SYNC_BYTE
        |=> paddr[ADDR_W-1:2] != REG_SYNC_BYTE || prdata[7:0] == $past(pwdata[7:0]))
        else $error("sync byte readback mismatch");

    // no result during reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result valid in reset");

endmodule

bind magic_id_length_deframer_unit mild_checker u_mild_checker (.*);
